>>> src/rasd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rasd_pkg
// shared codes, widths and constants of the ray / atom surface distance block
// ----------------------------------------------------------------------------
package rasd_pkg;

	// operation codes of the func field
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_CAST = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_PROBE = 3'd0;
	localparam logic [2:0] REG_CX    = 3'd1;
	localparam logic [2:0] REG_CY    = 3'd2;
	localparam logic [2:0] REG_CZ    = 3'd3;

	localparam int unsigned COORD_W = 20;
	localparam int unsigned RAD_W   = 12;
	localparam int unsigned DIR_W   = 16;
	localparam int unsigned OPND_W  = 24;
	localparam int unsigned PROD_W  = 48;
	localparam int unsigned DOT_W   = 38;
	localparam int unsigned H_W     = 50;
	localparam int unsigned BEST_W  = 27;

	// multiply sequence steps
	typedef enum logic [2:0] {
		OP_XS = 3'd0,
		OP_YS = 3'd1,
		OP_ZS = 3'd2,
		OP_RR = 3'd3,
		OP_XX = 3'd4,
		OP_YY = 3'd5,
		OP_ZZ = 3'd6,
		OP_TT = 3'd7
	} mul_op_t;

	localparam logic [BEST_W-1:0] ONE_ANGSTROM = BEST_W'(256);
	localparam logic [19:0]       DIST_MAX     = 20'hFFFFF;
	localparam logic [15:0]       COUNT_MAX    = 16'hFFFF;
	localparam logic [H_W-1:0]    SQRT_BIT0    = H_W'(1) << 48;

endpackage
`default_nettype wire

>>> src/ray_atom_surface_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_atom_surface_distance
// far-hit ray casting from the molecule centroid against probe-inflated atoms
// ----------------------------------------------------------------------------
// A load word (func 0) stores one atom and answers in the cycle right after it
// is accepted; a cast word (func 1) walks every stored atom with one shared
// 24x24 multiplier and a shift-and-subtract square root, and answers once
// the walk is over (per atom: memory read, latch, eight multiply/accumulate
// pairs, one shift, sqrt init, 25 root steps plus an exit check, compare,
// advance; an atom whose line misses skips the root steps and the compare).
// busy is high for the whole walk and start is ignored then. The result word
// stays on the outputs until the next answer; done is high for exactly one
// cycle with it, and the receiver cannot stall it. Configuration writes are
// taken at any time but belong to idle periods.
module ray_atom_surface_distance
	import rasd_pkg::*;
#(
	parameter int unsigned MAX_ATOMS = 256
) (
	input  wire                  clk,
	input  wire                  arst_n,
	// configuration port
	input  wire                  cfg_we,
	input  wire  [2:0]           cfg_addr,
	input  wire  [19:0]          cfg_data,
	// command side
	input  wire                  start,
	output logic                 busy,
	input  wire                  func,
	input  wire                  restart,
	input  wire  signed [19:0]   pos_x,
	input  wire  signed [19:0]   pos_y,
	input  wire  signed [19:0]   pos_z,
	input  wire  [11:0]          atom_radius,
	input  wire  signed [15:0]   dir_x,
	input  wire  signed [15:0]   dir_y,
	input  wire  signed [15:0]   dir_z,
	// result side
	output logic                 done,
	output logic [19:0]          surface_distance,
	output logic                 hit,
	output logic [15:0]          hit_count,
	output logic [8:0]           atoms_held,
	output logic                 table_full
);

	localparam int unsigned AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int unsigned CW = $clog2(MAX_ATOMS + 1);
	localparam int unsigned MW = 3 * COORD_W + RAD_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FETCH, ST_LATCH, ST_MUL, ST_ACC, ST_TSET,
		ST_HCHK, ST_SQRT, ST_CAND, ST_NEXT, ST_FINISH
	} state_t;

	state_t state_q;

	// configuration registers
	logic [11:0]        probe_q;
	logic signed [19:0] cx_q, cy_q, cz_q;

	// table bookkeeping
	logic [CW-1:0]      total_q;
	logic [15:0]        hits_q;
	logic [AW-1:0]      idx_q;

	// atom table, one word per atom: {x, y, z, r}
	logic [MW-1:0]      mem [MAX_ATOMS];
	logic [MW-1:0]      rdata_q;

	// ray and per-atom working registers
	logic signed [15:0] sx_q, sy_q, sz_q;
	logic signed [20:0] px_q, py_q, pz_q;
	logic [12:0]        r_q;
	mul_op_t            op_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DOT_W-1:0]  dot_q;
	logic signed [OPND_W-1:0] t_q;
	logic signed [H_W-1:0]    h_q;
	logic [H_W-1:0]     rem_q, res_q, bit_q;
	logic signed [BEST_W-1:0] best_q;

	// result registers
	logic               done_q;
	logic [19:0]        dist_q;
	logic               hit_q;
	logic               full_q;

	// load path
	logic               accept;
	logic [CW-1:0]      base_cnt;
	logic               room;
	logic               wr_en;
	logic [MW-1:0]      wr_word;

	// shared multiplier operands
	logic signed [OPND_W-1:0] op_a, op_b;

	// sqrt step and candidate root
	logic [H_W-1:0]     trial;
	logic signed [BEST_W-1:0] root;
	logic               last_atom;
	logic [31:0]        total_ext;

	assign accept    = start && (state_q == ST_IDLE);
	assign base_cnt  = restart ? '0 : total_q;
	assign room      = base_cnt < CW'(MAX_ATOMS);
	assign wr_en     = accept && (func == FUNC_LOAD) && room;
	assign wr_word   = {pos_x, pos_y, pos_z, atom_radius};
	assign last_atom = (CW'(idx_q) + CW'(1)) == total_q;

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (op_q)
			OP_XS: begin op_a = OPND_W'(px_q); op_b = OPND_W'(sx_q); end
			OP_YS: begin op_a = OPND_W'(py_q); op_b = OPND_W'(sy_q); end
			OP_ZS: begin op_a = OPND_W'(pz_q); op_b = OPND_W'(sz_q); end
			OP_RR: begin op_a = OPND_W'(r_q);  op_b = OPND_W'(r_q);  end
			OP_XX: begin op_a = OPND_W'(px_q); op_b = OPND_W'(px_q); end
			OP_YY: begin op_a = OPND_W'(py_q); op_b = OPND_W'(py_q); end
			OP_ZZ: begin op_a = OPND_W'(pz_q); op_b = OPND_W'(pz_q); end
			OP_TT: begin op_a = t_q;           op_b = t_q;           end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign trial = res_q + bit_q;
	assign root  = BEST_W'(t_q) + BEST_W'(res_q[24:0]);

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[base_cnt[AW-1:0]] <= wr_word;
		end
		rdata_q <= mem[idx_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= 12'd358;
			cx_q    <= '0;
			cy_q    <= '0;
			cz_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PROBE: probe_q <= cfg_data[11:0];
				REG_CX:    cx_q    <= cfg_data;
				REG_CY:    cy_q    <= cfg_data;
				REG_CZ:    cz_q    <= cfg_data;
				default:   ;
			endcase
		end
	end

	// sequencer with its datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			hits_q  <= '0;
			idx_q   <= '0;
			op_q    <= OP_XS;
			done_q  <= 1'b0;
			dist_q  <= '0;
			hit_q   <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (func == FUNC_LOAD) begin
							if (restart) begin
								hits_q <= '0;
							end
							total_q <= room ? base_cnt + CW'(1) : base_cnt;
							full_q  <= !room;
							dist_q  <= '0;
							hit_q   <= 1'b0;
							done_q  <= 1'b1;
						end else begin
							sx_q   <= dir_x;
							sy_q   <= dir_y;
							sz_q   <= dir_z;
							idx_q  <= '0;
							best_q <= ONE_ANGSTROM;
							state_q <= (total_q == '0) ? ST_FINISH : ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					// offsets from the centroid, radius inflated by the probe
					px_q  <= 21'(signed'(rdata_q[71:52])) - 21'(cx_q);
					py_q  <= 21'(signed'(rdata_q[51:32])) - 21'(cy_q);
					pz_q  <= 21'(signed'(rdata_q[31:12])) - 21'(cz_q);
					r_q   <= 13'(rdata_q[11:0]) + 13'(probe_q);
					dot_q <= '0;
					h_q   <= '0;
					op_q  <= OP_XS;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= op_a * op_b;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					case (op_q) inside
						OP_XS, OP_YS, OP_ZS: dot_q <= dot_q + DOT_W'(prod_q);
						OP_XX, OP_YY, OP_ZZ: h_q   <= h_q - H_W'(prod_q);
						default:             h_q   <= h_q + H_W'(prod_q);
					endcase
					if (op_q == OP_ZS) begin
						state_q <= ST_TSET;
					end else if (op_q == OP_TT) begin
						state_q <= ST_HCHK;
					end else begin
						op_q    <= mul_op_t'(op_q + 3'd1);
						state_q <= ST_MUL;
					end
				end
				ST_TSET: begin
					// floor shift by 14: the upper bits of the dot product
					t_q     <= dot_q[DOT_W-1:14];
					op_q    <= OP_RR;
					state_q <= ST_MUL;
				end
				ST_HCHK: begin
					rem_q <= h_q;
					res_q <= '0;
					bit_q <= SQRT_BIT0;
					state_q <= (h_q > 0) ? ST_SQRT : ST_NEXT;
				end
				ST_SQRT: begin
					if (bit_q == '0) begin
						state_q <= ST_CAND;
					end else begin
						if (rem_q >= trial) begin
							rem_q <= rem_q - trial;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				ST_CAND: begin
					if (root >= 0 && root > best_q) begin
						best_q <= root;
					end
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (last_atom) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_FINISH: begin
					dist_q <= (best_q > BEST_W'(DIST_MAX)) ? DIST_MAX : best_q[19:0];
					hit_q  <= best_q > ONE_ANGSTROM;
					if (best_q > ONE_ANGSTROM && hits_q != COUNT_MAX) begin
						hits_q <= hits_q + 16'd1;
					end
					full_q  <= 1'b0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign total_ext = 32'(total_q);

	assign busy             = (state_q != ST_IDLE);
	assign done             = done_q;
	assign surface_distance = dist_q;
	assign hit              = hit_q;
	assign hit_count        = hits_q;
	assign atoms_held       = total_ext[8:0];
	assign table_full       = full_q;

	// a hit word never carries a distance at or below one angstrom
	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!hit || surface_distance > 20'd256))
		else $error("hit flagged without distance");

	// a dropped load reports no distance and no hit
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_full) |-> (!hit && surface_distance == 20'd0))
		else $error("dropped load carries cast fields");

	// the atom count never passes the table depth
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_ATOMS))
		else $error("atom count beyond table depth");

	// a cast on a non-empty table keeps the block busy the next cycle
	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_CAST && total_q != '0) |=> busy)
		else $error("cast did not start the walk");

endmodule
`default_nettype wire
